[rtl/ffba_pkg.sv]
package ffba_pkg;

  localparam int BLOCKS = 64;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int ST_W   = 2;
  localparam int SUM_W  = CNT_W + 1;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic             tok;
    logic             found;
    logic [CNT_W-1:0] run;
    logic [IDX_W-1:0] head;
  } tok_t;

  // Range update broadcast to every cell
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

endpackage

[rtl/ffba_if.sv]
interface ffba_req_if;
  import ffba_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [IDX_W-1:0] start_block;
  logic [CNT_W-1:0] run_len;

  modport source (output valid, mode, start_block, run_len, input ready);
  modport sink (input valid, mode, start_block, run_len, output ready);
endinterface

interface ffba_rsp_if;
  import ffba_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] run_start;

  modport source (output valid, status, run_start, input ready);
  modport sink (input valid, status, run_start, output ready);
endinterface

[rtl/ffba_cell.sv]
module ffba_cell
  import ffba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  logic [CNT_W-1:0] count,
  input  tok_t             tin,
  input  range_t           rng,
  output tok_t             tout
);

  logic used;
  tok_t tok_next;
  logic in_range;
  logic [CNT_W-1:0] run_inc;

  assign in_range = (idx >= rng.lo) && (idx <= rng.hi);
  assign run_inc  = tin.run + CNT_W'(1);

  // Extend the free run, restart it at a used block, or pass on a run already found upstream
  always_comb begin
    tok_next     = tin;
    if (!tin.found) begin
      if (used) begin
        tok_next.run = '0;
      end else begin
        tok_next.run   = run_inc;
        tok_next.head  = (tin.run == '0) ? idx : tin.head;
        tok_next.found = (run_inc == count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      tout <= '0;
    end else begin
      tout <= tok_next;
      if (rng.set && in_range) begin
        used <= 1'b1;
      end else if (rng.clr && in_range) begin
        used <= 1'b0;
      end
    end
  end

endmodule

[rtl/first_fit_block_bitmap_allocator.sv]
// An allocate with a count of 1 to 64 sends the scan token walking the 64-cell chain
// one cell a cycle from acceptance to the result.
// Allocates of zero or too many blocks skip the scan; frees pass through S_FREE.
// Throughput: one item in flight; the next is accepted once the result is registered.
// Reset (rst, synchronous, active high) marks every block free and empties the
// output register.
module first_fit_block_bitmap_allocator
  import ffba_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  ffba_req_if.sink   req,
  ffba_rsp_if.source rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FREE = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state;
  logic             go;
  logic [IDX_W-1:0] start_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ST_W-1:0]  status_q;
  logic [IDX_W-1:0] where_q;

  logic             out_valid;
  logic [ST_W-1:0]  out_status;
  logic [IDX_W-1:0] out_start;

  tok_t   chain [BLOCKS+1];
  range_t rng;

  logic             accept;
  logic             bad_range;
  logic [SUM_W-1:0] free_end;
  logic [SUM_W-1:0] mark_end;
  logic             load_out;
  tok_t             last;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  // Free range checks: start + count must stay within the map
  assign free_end  = SUM_W'(start_q) + SUM_W'(cnt_q);
  assign bad_range = free_end > SUM_W'(BLOCKS);

  assign last     = chain[BLOCKS];
  assign mark_end = SUM_W'(last.head) + SUM_W'(cnt_q) - SUM_W'(1);

  // Broadcast the update range: clear on a legal free, set once a fit is found
  always_comb begin
    rng = '0;
    unique case (state)
      S_FREE: begin
        rng.clr = !bad_range && (cnt_q != '0);
        rng.lo  = start_q;
        rng.hi  = free_end[IDX_W-1:0] - IDX_W'(1);
      end
      S_SCAN: begin
        rng.set = last.tok && last.found;
        rng.lo  = last.head;
        rng.hi  = mark_end[IDX_W-1:0];
      end
      default: begin
        rng = '0;
      end
    endcase
  end

  // Token enters the head of the chain with an empty run
  assign chain[0] = '{tok: go, found: 1'b0, run: '0, head: '0};

  for (genvar i = 0; i < BLOCKS; i++) begin : g_cell
    ffba_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .idx   (IDX_W'(i)),
      .count (cnt_q),
      .tin   (chain[i]),
      .rng   (rng),
      .tout  (chain[i+1])
    );
  end

  assign load_out = (state == S_FIN) && (!out_valid || rsp.ready);

  // Sequencer: hold the request, launch the scan or the free, park the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      go    <= 1'b0;
    end else begin
      // Launch the token only for an allocate whose count can fit at all
      go <= accept && (req.mode == MODE_ALLOC) && (req.run_len != '0) &&
            (req.run_len <= CNT_W'(BLOCKS));
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.mode == MODE_FREE) begin
              state <= S_FREE;
            end else if (req.run_len == '0 ||
                         req.run_len > CNT_W'(BLOCKS)) begin
              state <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (last.tok) begin
            state <= S_FIN;
          end
        end
        S_FREE: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      start_q  <= req.start_block;
      cnt_q    <= req.run_len;
      status_q <= (req.mode == MODE_FREE) ? ST_DONE : ST_NOFIT;
      where_q  <= '0;
    end else if (state == S_FREE) begin
      if (bad_range && cnt_q != '0) begin
        status_q <= ST_BAD;
      end
    end else if (state == S_SCAN && last.tok && last.found) begin
      status_q <= ST_DONE;
      where_q  <= last.head;
    end
  end

  // Output register: drop valid once taken, load when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= status_q;
      out_start  <= where_q;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.run_start = out_start;

endmodule

[rtl/ffba_checker.sv]
module ffba_checker
  import ffba_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [ST_W-1:0]  status,
  input logic [IDX_W-1:0] run_start
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(run_start))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item taken while one is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_DONE || status == ST_NOFIT || status == ST_BAD))
    else $error("undefined status code");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_DONE |-> run_start == '0)
    else $error("run start not zero on failure");

endmodule

bind first_fit_block_bitmap_allocator ffba_checker u_ffba_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .run_start (rsp.run_start)
);
